>>> rtl/vdte_pkg.sv
// ----------------------------------------------------------------------------
// vdte_pkg
// types and constants shared by the video dma transfer engine
// ----------------------------------------------------------------------------
package vdte_pkg;

    localparam int unsigned SRC_W    = 22;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned VADDR_W  = 17;
    localparam int unsigned TADDR_W  = 24;
    localparam int unsigned DATA_W   = 16;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned TCODE_W  = 5;
    localparam int unsigned ACTION_W = 2;
    localparam int unsigned OP_W     = 3;
    localparam int unsigned PADDR_W  = 5;
    localparam int unsigned PDATA_W  = 32;
    localparam int unsigned SRC_LO_W = 16;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK  = 2'd0,
        ACT_START = 2'd1,
        ACT_DATA  = 2'd2
    } t_action;

    typedef enum logic [OP_W-1:0] {
        OP_NONE     = 3'd0,
        OP_BUS_READ = 3'd1,
        OP_PORT_WR  = 3'd2,
        OP_VID_READ = 3'd3,
        OP_VID_WR   = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        REG_ENABLE     = 3'd0,
        REG_MODE       = 3'd1,
        REG_SOURCE     = 3'd2,
        REG_LENGTH     = 3'd3,
        REG_FILL       = 3'd4,
        REG_INCREMENT  = 3'd5,
        REG_TARGET     = 3'd6,
        REG_ADDR_START = 3'd7
    } t_reg_idx;

    localparam logic [1:0] MODE_FILL = 2'd2;
    localparam logic [3:0] TGT_VRAM  = 4'd1;

    typedef struct packed {
        logic               dma_enable;
        logic [1:0]         dma_mode;
        logic [SRC_W-1:0]   source_start;
        logic [LEN_W-1:0]   length_start;
        logic [BYTE_W-1:0]  fill_byte;
        logic [BYTE_W-1:0]  address_increment;
        logic [TCODE_W-1:0] target_code;
        logic [VADDR_W-1:0] address_start;
    } t_cfg;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                hold;
        logic [DATA_W-1:0]   read_data;
    } t_in_beat;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [TADDR_W-1:0] target_address;
        logic [DATA_W-1:0]  write_data;
        logic               busy_res;
        logic               done_res;
    } t_out_beat;

endpackage

>>> rtl/vdte_in_if.sv
// ----------------------------------------------------------------------------
// vdte_in_if
// input channel of the video dma transfer engine
// ----------------------------------------------------------------------------
interface vdte_in_if;

    logic                          valid;
    logic                          ready;
    logic [vdte_pkg::ACTION_W-1:0] action;
    logic                          hold;
    logic [vdte_pkg::DATA_W-1:0]   read_data;

    modport source (output valid, action, hold, read_data, input ready);
    modport sink   (input valid, action, hold, read_data, output ready);

endinterface

>>> rtl/vdte_out_if.sv
// ----------------------------------------------------------------------------
// vdte_out_if
// result channel of the video dma transfer engine
// ----------------------------------------------------------------------------
interface vdte_out_if;

    logic                         valid;
    logic                         ready;
    logic [vdte_pkg::OP_W-1:0]    operation;
    logic [vdte_pkg::TADDR_W-1:0] target_address;
    logic [vdte_pkg::DATA_W-1:0]  write_data;
    logic                         busy_res;
    logic                         done_res;

    modport source (output valid, operation, target_address, write_data, busy_res, done_res,
                    input ready);
    modport sink   (input valid, operation, target_address, write_data, busy_res, done_res,
                    output ready);

endinterface

>>> rtl/vdte_cfg_regs.sv
// ----------------------------------------------------------------------------
// vdte_cfg_regs
// apb register file holding the dma configuration
// ----------------------------------------------------------------------------
module vdte_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [vdte_pkg::PADDR_W-1:0]  paddr,
    input  logic [vdte_pkg::PDATA_W-1:0]  pwdata,
    output logic [vdte_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output vdte_pkg::t_cfg                o_cfg
);

    vdte_pkg::t_cfg      r_cfg;
    vdte_pkg::t_reg_idx  reg_idx;
    logic                wr_en;

    assign pready  = 1'b1;
    assign reg_idx = vdte_pkg::t_reg_idx'(paddr[vdte_pkg::PADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                vdte_pkg::REG_ENABLE:     r_cfg.dma_enable        <= pwdata[0];
                vdte_pkg::REG_MODE:       r_cfg.dma_mode          <= pwdata[1:0];
                vdte_pkg::REG_SOURCE:     r_cfg.source_start      <= pwdata[vdte_pkg::SRC_W-1:0];
                vdte_pkg::REG_LENGTH:     r_cfg.length_start      <= pwdata[vdte_pkg::LEN_W-1:0];
                vdte_pkg::REG_FILL:       r_cfg.fill_byte         <= pwdata[vdte_pkg::BYTE_W-1:0];
                vdte_pkg::REG_INCREMENT:  r_cfg.address_increment <= pwdata[vdte_pkg::BYTE_W-1:0];
                vdte_pkg::REG_TARGET:     r_cfg.target_code       <= pwdata[vdte_pkg::TCODE_W-1:0];
                vdte_pkg::REG_ADDR_START: r_cfg.address_start     <= pwdata[vdte_pkg::VADDR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_idx)
            vdte_pkg::REG_ENABLE:     prdata = 32'(r_cfg.dma_enable);
            vdte_pkg::REG_MODE:       prdata = 32'(r_cfg.dma_mode);
            vdte_pkg::REG_SOURCE:     prdata = 32'(r_cfg.source_start);
            vdte_pkg::REG_LENGTH:     prdata = 32'(r_cfg.length_start);
            vdte_pkg::REG_FILL:       prdata = 32'(r_cfg.fill_byte);
            vdte_pkg::REG_INCREMENT:  prdata = 32'(r_cfg.address_increment);
            vdte_pkg::REG_TARGET:     prdata = 32'(r_cfg.target_code);
            vdte_pkg::REG_ADDR_START: prdata = 32'(r_cfg.address_start);
            default:                  prdata = '0;
        endcase
    end

endmodule

>>> rtl/video_dma_transfer_engine_top.sv
// ----------------------------------------------------------------------------
// video_dma_transfer_engine_top
// video dma engine stepping one transfer per input beat
// ----------------------------------------------------------------------------
// Each input beat (tick, start or returned read data) yields exactly one
// result beat naming the bus or video operation to perform, if any. The
// engine takes one beat per clock while results are not held up: a taken beat
// sits in the input register while the step logic works out the result
// register's next value. A new beat is taken while a result still waits, as
// long as the input register is free. Configuration is to be written over the
// apb port only while the engine is idle; the block does not enforce this.
module video_dma_transfer_engine_top #(
    parameter int unsigned ADDRESS_BITS = 17
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [vdte_pkg::PADDR_W-1:0]  paddr,
    input  logic [vdte_pkg::PDATA_W-1:0]  pwdata,
    output logic [vdte_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    vdte_in_if.sink                       i_in,
    vdte_out_if.source                    o_out
);

    vdte_pkg::t_cfg       cfg;

    logic                       r_in_vld;
    vdte_pkg::t_in_beat         r_in;
    logic                       r_out_vld;
    vdte_pkg::t_out_beat        r_out;

    logic [vdte_pkg::SRC_W-1:0] r_src,     n_src;
    logic [vdte_pkg::LEN_W-1:0] r_remain,  n_remain;
    logic [ADDRESS_BITS-1:0]    r_vaddr,   n_vaddr;
    logic                       r_pending, n_pending;
    logic                       r_await,   n_await;
    logic                       r_await_copy, n_await_copy;

    logic                       advance;
    logic                       step;
    logic                       fin;
    logic                       fin_video;
    logic [vdte_pkg::LEN_W-1:0] remain_dec;
    vdte_pkg::t_out_beat        res;

    vdte_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign advance    = !r_out_vld || o_out.ready;
    assign step       = r_in_vld && advance;
    assign i_in.ready = !r_in_vld || advance;
    assign remain_dec = r_remain - 16'd1;

    always_comb begin
        n_src        = r_src;
        n_remain     = r_remain;
        n_vaddr      = r_vaddr;
        n_pending    = r_pending;
        n_await      = r_await;
        n_await_copy = r_await_copy;
        fin          = 1'b0;
        fin_video    = 1'b0;
        res          = '0;
        case (vdte_pkg::t_action'(r_in.action))
            vdte_pkg::ACT_START: begin
                n_src        = cfg.source_start;
                n_remain     = cfg.length_start;
                n_vaddr      = cfg.address_start[ADDRESS_BITS-1:0];
                n_pending    = 1'b1;
                n_await      = 1'b0;
                n_await_copy = 1'b0;
            end
            vdte_pkg::ACT_DATA: begin
                if (r_await) begin
                    n_await = 1'b0;
                    fin     = 1'b1;
                    if (r_await_copy) begin
                        fin_video          = 1'b1;
                        res.operation      = vdte_pkg::OP_VID_WR;
                        res.target_address = {{(vdte_pkg::TADDR_W-ADDRESS_BITS){1'b0}}, r_vaddr};
                        res.write_data     = {8'd0, r_in.read_data[vdte_pkg::BYTE_W-1:0]};
                    end else begin
                        res.operation  = vdte_pkg::OP_PORT_WR;
                        res.write_data = r_in.read_data;
                    end
                end
            end
            vdte_pkg::ACT_TICK: begin
                if (!r_await && r_pending && cfg.dma_enable && !r_in.hold) begin
                    if (!cfg.dma_mode[1]) begin
                        res.operation      = vdte_pkg::OP_BUS_READ;
                        res.target_address = {cfg.dma_mode[0], r_src, 1'b0};
                        n_await            = 1'b1;
                        n_await_copy       = 1'b0;
                    end else if (cfg.dma_mode == vdte_pkg::MODE_FILL) begin
                        fin       = 1'b1;
                        fin_video = 1'b1;
                        if (cfg.target_code[3:0] == vdte_pkg::TGT_VRAM) begin
                            res.operation      = vdte_pkg::OP_VID_WR;
                            res.target_address =
                                {{(vdte_pkg::TADDR_W-ADDRESS_BITS){1'b0}}, r_vaddr};
                            res.write_data     = {8'd0, cfg.fill_byte};
                        end
                    end else if (cfg.target_code[4]) begin
                        res.operation      = vdte_pkg::OP_VID_READ;
                        res.target_address =
                            {{(vdte_pkg::TADDR_W-ADDRESS_BITS){1'b0}}, r_src[ADDRESS_BITS-1:0]};
                        n_await            = 1'b1;
                        n_await_copy       = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        if (fin) begin
            n_src    = {r_src[vdte_pkg::SRC_W-1:vdte_pkg::SRC_LO_W],
                        r_src[vdte_pkg::SRC_LO_W-1:0] + 16'd1};
            n_remain = remain_dec;
            if (fin_video) begin
                n_vaddr = r_vaddr + {{(ADDRESS_BITS-vdte_pkg::BYTE_W){1'b0}},
                                     cfg.address_increment};
            end
            if (remain_dec == '0) begin
                n_pending    = 1'b0;
                res.done_res = 1'b1;
            end
        end
        res.busy_res = n_pending;
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.action    <= i_in.action;
            r_in.hold      <= i_in.hold;
            r_in.read_data <= i_in.read_data;
        end
    end

    // transfer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src        <= '0;
            r_remain     <= '0;
            r_vaddr      <= '0;
            r_pending    <= 1'b0;
            r_await      <= 1'b0;
            r_await_copy <= 1'b0;
        end else if (step) begin
            r_src        <= n_src;
            r_remain     <= n_remain;
            r_vaddr      <= n_vaddr;
            r_pending    <= n_pending;
            r_await      <= n_await;
            r_await_copy <= n_await_copy;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= res;
        end
    end

    assign o_out.valid          = r_out_vld;
    assign o_out.operation      = r_out.operation;
    assign o_out.target_address = r_out.target_address;
    assign o_out.write_data     = r_out.write_data;
    assign o_out.busy_res       = r_out.busy_res;
    assign o_out.done_res       = r_out.done_res;

`ifndef NO_ASSERTIONS
    a_await_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_await |-> r_pending)
        else $error("read outstanding without a pending transfer");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.done_res |-> !r_out.busy_res)
        else $error("done beat still reports busy");

    a_done_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.done_res |->
            r_out.operation != vdte_pkg::OP_BUS_READ &&
            r_out.operation != vdte_pkg::OP_VID_READ)
        else $error("done beat carries a read request");
`endif

endmodule
